>>> hw/rtl/ptt_pkg.sv
// ============================================================================
// Priority task table package
// Field widths, command and status codes, default sizes and the command and
// status bundles shared by the controller, the datapath and the top level.
// ============================================================================
package ptt_pkg;

   // Default sizes of the table.
   localparam int TABLE_DEPTH_DEF   = 64;
   localparam int ID_BITS_DEF       = 16;
   localparam int PRIORITY_BITS_DEF = 32;

   // Fixed widths of the request and response fields.
   localparam int OP_W       = 2;
   localparam int USER_W     = 16;
   localparam int TASK_W     = 16;
   localparam int PRIO_W     = 32;
   localparam int OWNER_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = USER_W + TASK_W + PRIO_W;
   localparam int RSP_DATA_W = OWNER_W;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Command codes.
   localparam op_type OP_ADD    = 2'd0;
   localparam op_type OP_EDIT   = 2'd1;
   localparam op_type OP_REMOVE = 2'd2;
   localparam op_type OP_EXEC   = 2'd3;

   // Response status codes.
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_FULL     = 2'd1;
   localparam status_type ST_EMPTY    = 2'd2;
   localparam status_type ST_NOTFOUND = 2'd3;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;    // capture a new request and clear the scan results
      logic scan;    // read the slot under the scan pointer and advance it
      logic commit;  // apply the scan results and load the response register
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_last;  // the scan pointer sits on the last slot
      logic out_free;   // the response register can take a new response
   } ctrl_sts_type;

endpackage

>>> hw/rtl/ptt_controller.sv
// ============================================================================
// Priority task table controller
// Sequences one request through load, table scan, drain and commit.
// ============================================================================
module ptt_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  ptt_pkg::ctrl_sts_type ctrl_sts,
   output ptt_pkg::ctrl_cmd_type ctrl_cmd
);
   import ptt_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      ctrl_cmd.load   = 1'b0;
      ctrl_cmd.scan   = 1'b0;
      ctrl_cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl_cmd.load = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            ctrl_cmd.scan = 1'b1;
            if (ctrl_sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last slot read is being compared in this cycle.
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (ctrl_sts.out_free) begin
               ctrl_cmd.commit = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/ptt_datapath.sv
// ============================================================================
// Priority task table datapath
// Entry memory, valid bits, scan pointer, compare stage and response register.
// ============================================================================
module ptt_datapath #(
   parameter int TABLE_DEPTH   = ptt_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS       = ptt_pkg::ID_BITS_DEF,
   parameter int PRIORITY_BITS = ptt_pkg::PRIORITY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ptt_pkg::ctrl_cmd_type       ctrl_cmd,
   output ptt_pkg::ctrl_sts_type       ctrl_sts,
   input  ptt_pkg::op_type             req_op,
   input  logic [ptt_pkg::USER_W-1:0]  req_user,
   input  logic [ptt_pkg::TASK_W-1:0]  req_task,
   input  logic [ptt_pkg::PRIO_W-1:0]  req_prio,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ptt_pkg::OWNER_W-1:0] rsp_owner,
   output ptt_pkg::status_type         rsp_status
);
   import ptt_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W = 2 * ID_BITS + PRIORITY_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // Entry word layout from the low bits up: task id, user id, priority.
   logic [ENTRY_W-1:0] mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   // Captured request.
   op_type                   cmd_op_ff;
   logic [ID_BITS-1:0]       cmd_user_ff;
   logic [ID_BITS-1:0]       cmd_task_ff;
   logic [PRIORITY_BITS-1:0] cmd_prio_ff;

   // Scan pointer and read stage.
   logic [IDX_W-1:0]   scan_idx_ff;
   logic               rd_en_ff;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [ENTRY_W-1:0] rd_word_ff;

   // Compare stage results.
   logic                     match_found_ff;
   logic [IDX_W-1:0]         match_idx_ff;
   logic [ID_BITS-1:0]       match_user_ff;
   logic                     free_found_ff;
   logic [IDX_W-1:0]         free_idx_ff;
   logic                     best_found_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [PRIORITY_BITS-1:0] best_prio_ff;
   logic [ID_BITS-1:0]       best_task_ff;
   logic [ID_BITS-1:0]       best_user_ff;

   // Response register.
   logic               rsp_valid_ff;
   logic [OWNER_W-1:0] rsp_owner_ff;
   status_type         rsp_status_ff;

   logic [ID_BITS-1:0]       rd_task;
   logic [ID_BITS-1:0]       rd_user;
   logic [PRIORITY_BITS-1:0] rd_prio;
   logic                     rd_better;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [ENTRY_W-1:0] wr_word;
   logic               vld_set;
   logic               vld_clr;
   logic [IDX_W-1:0]   vld_idx;
   status_type         status_in;
   logic [OWNER_W-1:0] owner_in;

   assign rd_task = rd_word_ff[ID_BITS-1:0];
   assign rd_user = rd_word_ff[2*ID_BITS-1:ID_BITS];
   assign rd_prio = rd_word_ff[ENTRY_W-1:2*ID_BITS];

   assign rd_better = !best_found_ff || (rd_prio > best_prio_ff) ||
                      ((rd_prio == best_prio_ff) && (rd_task > best_task_ff));

   assign ctrl_sts.scan_last = (scan_idx_ff == LAST_IDX);
   assign ctrl_sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_owner  = rsp_owner_ff;
   assign rsp_status = rsp_status_ff;

   // Request capture and scan pointer.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_op_ff   <= req_op;
         cmd_user_ff <= ID_BITS'(req_user);
         cmd_task_ff <= ID_BITS'(req_task);
         cmd_prio_ff <= PRIORITY_BITS'(req_prio);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_en_ff    <= 1'b0;
      end else begin
         rd_en_ff <= ctrl_cmd.scan;
         if (ctrl_cmd.load) begin
            scan_idx_ff <= '0;
         end else if (ctrl_cmd.scan && !ctrl_sts.scan_last) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         end
      end
   end

   // Memory: one registered read per cycle during the scan, one write at commit.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.scan) begin
         rd_word_ff  <= mem_ff[scan_idx_ff];
         rd_valid_ff <= valid_ff[scan_idx_ff];
         rd_idx_ff   <= scan_idx_ff;
      end
      if (ctrl_cmd.commit && wr_en) begin
         mem_ff[wr_idx] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl_cmd.commit) begin
         if (vld_set) begin
            valid_ff[vld_idx] <= 1'b1;
         end else if (vld_clr) begin
            valid_ff[vld_idx] <= 1'b0;
         end
      end
   end

   // Compare stage: first matching id, first free slot, best live task.
   always_ff @(posedge clock) begin
      if (reset || ctrl_cmd.load) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         best_found_ff  <= 1'b0;
      end else if (rd_en_ff) begin
         if (rd_valid_ff && (rd_task == cmd_task_ff) && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= rd_idx_ff;
            match_user_ff  <= rd_user;
         end
         if (!rd_valid_ff && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= rd_idx_ff;
         end
         if (rd_valid_ff && rd_better) begin
            best_found_ff <= 1'b1;
            best_idx_ff   <= rd_idx_ff;
            best_prio_ff  <= rd_prio;
            best_task_ff  <= rd_task;
            best_user_ff  <= rd_user;
         end
      end
   end

   // Commit decision.
   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = match_idx_ff;
      wr_word   = {cmd_prio_ff, cmd_user_ff, cmd_task_ff};
      vld_set   = 1'b0;
      vld_clr   = 1'b0;
      vld_idx   = match_idx_ff;
      status_in = ST_OK;
      owner_in  = '0;
      case (cmd_op_ff)
         OP_ADD: begin
            if (match_found_ff) begin
               wr_en = 1'b1;
            end else if (free_found_ff) begin
               wr_en   = 1'b1;
               wr_idx  = free_idx_ff;
               vld_set = 1'b1;
               vld_idx = free_idx_ff;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_EDIT: begin
            if (match_found_ff) begin
               wr_en   = 1'b1;
               wr_word = {cmd_prio_ff, match_user_ff, cmd_task_ff};
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         OP_REMOVE: begin
            if (match_found_ff) begin
               vld_clr = 1'b1;
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         OP_EXEC: begin
            if (best_found_ff) begin
               vld_clr  = 1'b1;
               vld_idx  = best_idx_ff;
               owner_in = OWNER_W'(best_user_ff);
            end else begin
               status_in = ST_EMPTY;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) begin
         rsp_owner_ff  <= owner_in;
         rsp_status_ff <= status_in;
      end
   end

endmodule

>>> hw/rtl/priority_task_table.sv
// ============================================================================
// Priority task table
// Indexed priority queue of live tasks with add, edit, remove and execute-top.
// ============================================================================
// A new request is taken only after the previous one has committed. Each request
// scans the entry memory one slot per cycle through its single registered read
// port; the last slot read is then compared, and the result is committed to the
// response register, which waits while the previous response is still not taken.
// Reset is synchronous and active high; it empties the table and the response
// register. Entry contents are not cleared; each slot is gated by its valid bit.
module priority_task_table #(
   parameter int TABLE_DEPTH   = ptt_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS       = ptt_pkg::ID_BITS_DEF,
   parameter int PRIORITY_BITS = ptt_pkg::PRIORITY_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata from bit 0 up: user_id[15:0], task_id[31:16], priority_req[63:32].
   input  logic [ptt_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: op[1:0].
   input  ptt_pkg::op_type                req_tuser,
   // Response channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata from bit 0 up: owner_out[15:0].
   output logic [ptt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status[1:0].
   output ptt_pkg::status_type            rsp_tuser
);
   import ptt_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   ctrl_sts_type ctrl_sts;

   logic [USER_W-1:0] req_user;
   logic [TASK_W-1:0] req_task;
   logic [PRIO_W-1:0] req_prio;

   // Unpack the request fields from tdata.
   assign req_user = req_tdata[USER_W-1:0];
   assign req_task = req_tdata[USER_W+TASK_W-1:USER_W];
   assign req_prio = req_tdata[REQ_DATA_W-1:USER_W+TASK_W];

   // The controller walks each request through load, scan, drain and commit.
   ptt_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ctrl_sts   (ctrl_sts),
      .ctrl_cmd   (ctrl_cmd)
   );

   // The datapath holds the table, does the compares and owns the response
   // register, so a finished response can wait while the next request is taken.
   ptt_datapath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .ID_BITS       (ID_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl_cmd   (ctrl_cmd),
      .ctrl_sts   (ctrl_sts),
      .req_op     (req_tuser),
      .req_user   (req_user),
      .req_task   (req_task),
      .req_prio   (req_prio),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_owner  (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

   // A commit never overwrites a response that has not been taken.
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("commit while the response register is still occupied");

   // A response appears only in the cycle after a commit.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl_cmd.commit))
      else $error("response raised without a commit");

   // Only one request is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load |=> !req_tready)
      else $error("request taken while another is in work");

   // Scan and commit never coincide with taking a request.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.load, ctrl_cmd.scan, ctrl_cmd.commit}))
      else $error("controller issued overlapping commands");

endmodule
